>>> design/scratchpad_crc8_temperature_check_unit_macros.svh
// assertion macros shared by the scratchpad crc8 check design
`ifndef SCRATCHPAD_CRC8_TEMPERATURE_CHECK_UNIT_MACROS_SVH
`define SCRATCHPAD_CRC8_TEMPERATURE_CHECK_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SCRC8_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define SCRC8_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/scrc8_pkg.sv
// types, constants and the crc-8 byte update for the scratchpad check
package scrc8_pkg;

  localparam int unsigned CountW = 4;
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;

  localparam logic KindBusReset = 1'b0;
  localparam logic KindData     = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } step_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] temperature;
    logic               crc_ok;
  } result_t;

  // reflected crc-8, one data byte, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

>>> design/scrc8_frame_tracker.sv
// frame state: byte counter, running crc, captured temperature bytes
module scrc8_frame_tracker #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  scrc8_pkg::step_t   step_i,
  output scrc8_pkg::result_t result_o
);
  import scrc8_pkg::*;

  `include "scratchpad_crc8_temperature_check_unit_macros.svh"

  localparam logic [CountW-1:0] LastCount = CountW'(FRAME_BYTES);
  localparam logic [CountW-1:0] LastIndex = CountW'(FRAME_BYTES - 1);

  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        low_q, low_d;
  logic [7:0]        high_q, high_d;
  logic              frame_done;
  logic              take_byte;

  assign frame_done = (count_q >= LastCount);
  // data byte that the frame still needs, whether or not it is taken this cycle
  assign take_byte  = (step_i.kind == KindData) && !frame_done;

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    low_d   = low_q;
    high_d  = high_q;
    if (step_en_i && (step_i.kind == KindBusReset)) begin
      count_d = '0;
      crc_d   = CrcInit;
    end else if (step_en_i && take_byte) begin
      crc_d   = crc8_byte(crc_q, step_i.data_byte);
      count_d = count_q + CountW'(1);
      if (count_q == CountW'(0)) begin
        low_d = step_i.data_byte;
      end
      if (count_q == CountW'(1)) begin
        high_d = step_i.data_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= CrcInit;
      low_q   <= '0;
      high_q  <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // high when the pending item is the byte that completes the frame
  assign result_o.valid       = take_byte && (count_q == LastIndex);
  assign result_o.temperature = {high_d, low_d};
  assign result_o.crc_ok      = (crc_d == 8'h00);

  `SCRC8_ASSERT_IMP(a_count_bounded, clk_i, rst_ni, 1'b1, count_q <= LastCount)
  `SCRC8_ASSERT_NXT(a_bus_reset_clears, clk_i, rst_ni,
                    step_en_i && (step_i.kind == KindBusReset),
                    (count_q == '0) && (crc_q == CrcInit))
  `SCRC8_ASSERT_NXT(a_result_ends_frame, clk_i, rst_ni, step_en_i && result_o.valid,
                    frame_done)

endmodule

>>> design/scratchpad_crc8_temperature_check_unit.sv
// top level: input register, frame tracker and result register
// Usage: the input channel carries one item per cycle: kind_i low is a bus
// reset that starts a new frame, kind_i high carries one received scratchpad
// byte on data_byte_i. Every item is accepted while in_ready_o is high.
// The result channel gives one item per complete frame, on the byte that
// completes it: temperature_o is the signed Q12.4 word built from frame
// bytes 1 and 0, crc_ok_o is high when the crc-8 residue over the frame is
// zero. A frame with a bad crc still produces its result.
// The last byte goes through the input register, then the result register,
// before out_valid_o rises; a stall can hold it in the input register.
// Throughput: one item per cycle unless a result waits; the crc-8 byte update
// and the counter compare sit between the input and the result register.
// Reset clears the byte counter and crc, so bytes before any bus reset start
// a frame. Bytes after a full frame are dropped until the next bus reset.
// When the receiver stalls, the result holds; the input register keeps
// taking items that give no result, and an item that would give a result
// waits in the input register until the result register is free.
module scratchpad_crc8_temperature_check_unit #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] temperature_o,
  output logic               crc_ok_o
);
  import scrc8_pkg::*;

  logic               s1_valid_q, s1_valid_d;
  step_t              s1_step_q;
  logic               s1_fire;
  logic               out_free;
  result_t            res;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] temp_q;
  logic               crc_ok_q;

  assign out_free = !out_valid_q || out_ready_i;
  // items with no result pass even while the result register is full
  assign s1_fire  = s1_valid_q && (out_free || !res.valid);
  assign in_ready_o = !s1_valid_q || s1_fire;

  assign s1_valid_d  = (in_valid_i && in_ready_o) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = (s1_fire && res.valid) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_step_q.kind      <= kind_i;
      s1_step_q.data_byte <= data_byte_i;
    end
    if (s1_fire && res.valid) begin
      temp_q   <= res.temperature;
      crc_ok_q <= res.crc_ok;
    end
  end

  scrc8_frame_tracker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(s1_fire),
    .step_i   (s1_step_q),
    .result_o (res)
  );

  assign out_valid_o   = out_valid_q;
  assign temperature_o = temp_q;
  assign crc_ok_o      = crc_ok_q;

endmodule
